@@ rtl/servo_level_ramp_controller_defines.svh @@
// ----------------------------------------------------------------------------
// Servo level ramp controller assertion macros
// Shared property forms for the port checker, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef SERVO_LEVEL_RAMP_CONTROLLER_DEFINES_SVH
`define SERVO_LEVEL_RAMP_CONTROLLER_DEFINES_SVH

// Same-cycle implication
`define SLRC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SLRC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/slrc_pkg.sv @@
// ----------------------------------------------------------------------------
// Servo level ramp controller package
// Field widths, mapping and delay constants, codes and the stage item type.
// ----------------------------------------------------------------------------
package slrc_pkg;

    // Field widths
    localparam int ANGLE_W = 8;
    localparam int LEVEL_W = 7;
    localparam int DUR_W   = 10;
    localparam int TICK_W  = 13;

    // Angle limit and hold length when the goal is already reached
    localparam logic [ANGLE_W-1:0] MAX_ANGLE        = 8'd180;
    localparam logic [TICK_W-1:0]  EQUAL_HOLD_TICKS = 13'd1000;

    // Divide by 100: multiply by ceil(2^21/100), exact for magnitudes below 2^15
    localparam logic [14:0] DIV100_RECIP = 15'd20972;
    localparam int          DIV100_SHIFT = 21;

    // Step delay: duration * 50 / 9, the divide as ceil(2^19/9), exact below 2^16
    localparam logic [15:0] DUR_SCALE   = 16'd50;
    localparam logic [15:0] DIV9_RECIP  = 16'd58255;
    localparam int          DIV9_SHIFT  = 19;

    // Configuration register indexes
    localparam logic [1:0] CFG_ZERO_LEVEL_ANGLE  = 2'd0;
    localparam logic [1:0] CFG_FULL_LEVEL_ANGLE  = 2'd1;
    localparam logic [1:0] CFG_DETACH_AFTER_MOVE = 2'd2;

    // Input commands
    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Item handed from the mapping stages to the state update
    typedef struct packed {
        logic               cmd;
        logic [LEVEL_W-1:0] level;
        logic [DUR_W-1:0]   duration;
        logic [ANGLE_W-1:0] goal;
        logic [TICK_W-1:0]  delay;
    } slrc_item_t;

endpackage

@@ rtl/servo_level_ramp_controller.sv @@
// Stages: an accepted item passes the map product, then the reciprocal divide
// and clamp, then the state update into the result registers.
// Throughput: one item per cycle; the three stages advance together and hold
// only while a shown result is stalled. Reset clears angle, goal, counters,
// moving and drive, and loads the angle endpoints 0 and 180 with detach off.
// ----------------------------------------------------------------------------
// Servo level ramp controller
// Maps set levels onto an angle range and slews the driven angle one degree
// per step on millisecond ticks, with hold and optional drive detach.
// ----------------------------------------------------------------------------
module servo_level_ramp_controller
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [7:0]                      cfg_data,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            cmd,
    input  logic [slrc_pkg::LEVEL_W-1:0]    level,
    input  logic [slrc_pkg::DUR_W-1:0]      duration,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [slrc_pkg::ANGLE_W-1:0]    angle,
    output logic [slrc_pkg::ANGLE_W-1:0]    target_angle,
    output logic                            drive_on,
    output logic                            busy_res,
    output logic [slrc_pkg::LEVEL_W-1:0]    reported_level,
    output logic [slrc_pkg::DUR_W-1:0]      reported_duration
);

    logic                           advance;
    logic                           item_valid;
    slrc_pkg::slrc_item_t           item;

    // Configuration registers
    logic [slrc_pkg::ANGLE_W-1:0]   zero_angle_reg;
    logic [slrc_pkg::ANGLE_W-1:0]   full_angle_reg;
    logic                           detach_reg;

    // Controller state, shown directly as the result
    logic                           out_valid_reg;
    logic [slrc_pkg::ANGLE_W-1:0]   cur_angle_reg;
    logic [slrc_pkg::ANGLE_W-1:0]   cur_angle_next;
    logic [slrc_pkg::ANGLE_W-1:0]   goal_angle_reg;
    logic [slrc_pkg::ANGLE_W-1:0]   goal_angle_next;
    logic [slrc_pkg::TICK_W-1:0]    countdown_reg;
    logic [slrc_pkg::TICK_W-1:0]    countdown_next;
    logic [slrc_pkg::TICK_W-1:0]    countdown_dec;
    logic [slrc_pkg::TICK_W-1:0]    step_delay_reg;
    logic [slrc_pkg::TICK_W-1:0]    step_delay_next;
    logic                           moving_reg;
    logic                           moving_next;
    logic                           attached_reg;
    logic                           attached_next;
    logic [slrc_pkg::LEVEL_W-1:0]   last_level_reg;
    logic [slrc_pkg::LEVEL_W-1:0]   last_level_next;
    logic [slrc_pkg::DUR_W-1:0]     last_duration_reg;
    logic [slrc_pkg::DUR_W-1:0]     last_duration_next;

    // Move the whole pipe unless a shown result is stalled
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;

    slrc_map u_map
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_valid   (in_valid),
        .cmd        (cmd),
        .level      (level),
        .duration   (duration),
        .zero_angle (zero_angle_reg),
        .full_angle (full_angle_reg),
        .item_valid (item_valid),
        .item       (item)
    );

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_angle_reg <= '0;
            full_angle_reg <= slrc_pkg::MAX_ANGLE;
            detach_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                slrc_pkg::CFG_ZERO_LEVEL_ANGLE:  zero_angle_reg <= cfg_data;
                slrc_pkg::CFG_FULL_LEVEL_ANGLE:  full_angle_reg <= cfg_data;
                slrc_pkg::CFG_DETACH_AFTER_MOVE: detach_reg     <= cfg_data[0];
                default:                         ;
            endcase
        end
    end

    // Apply one set or tick item to the ramp state
    always_comb
    begin
        cur_angle_next     = cur_angle_reg;
        goal_angle_next    = goal_angle_reg;
        countdown_next     = countdown_reg;
        step_delay_next    = step_delay_reg;
        moving_next        = moving_reg;
        attached_next      = attached_reg;
        last_level_next    = last_level_reg;
        last_duration_next = last_duration_reg;
        countdown_dec      = (countdown_reg != '0) ? (countdown_reg - 1'b1) : countdown_reg;

        if (item.cmd == slrc_pkg::CMD_SET)
        begin
            // Start a new move from the driven angle; first step right away
            last_level_next    = item.level;
            last_duration_next = item.duration;
            goal_angle_next    = item.goal;
            step_delay_next    = item.delay;
            attached_next      = 1'b1;
            moving_next        = 1'b1;
            if (item.goal == cur_angle_reg)
            begin
                countdown_next = slrc_pkg::EQUAL_HOLD_TICKS;
            end
            else
            begin
                cur_angle_next = (item.goal > cur_angle_reg) ? (cur_angle_reg + 1'b1)
                                                             : (cur_angle_reg - 1'b1);
                countdown_next = item.delay;
            end
        end
        else if (moving_reg)
        begin
            // Count down; at zero step once more or finish the move
            countdown_next = countdown_dec;
            if (countdown_dec == '0)
            begin
                if (cur_angle_reg != goal_angle_reg)
                begin
                    cur_angle_next = (goal_angle_reg > cur_angle_reg) ? (cur_angle_reg + 1'b1)
                                                                      : (cur_angle_reg - 1'b1);
                    countdown_next = step_delay_reg;
                end
                else
                begin
                    moving_next = 1'b0;
                    if (detach_reg)
                    begin
                        attached_next = 1'b0;
                    end
                end
            end
        end
    end

    // Hold state and the result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            cur_angle_reg     <= '0;
            goal_angle_reg    <= '0;
            countdown_reg     <= '0;
            step_delay_reg    <= '0;
            moving_reg        <= 1'b0;
            attached_reg      <= 1'b0;
            last_level_reg    <= '0;
            last_duration_reg <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= item_valid;
            if (item_valid)
            begin
                cur_angle_reg     <= cur_angle_next;
                goal_angle_reg    <= goal_angle_next;
                countdown_reg     <= countdown_next;
                step_delay_reg    <= step_delay_next;
                moving_reg        <= moving_next;
                attached_reg      <= attached_next;
                last_level_reg    <= last_level_next;
                last_duration_reg <= last_duration_next;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign angle             = cur_angle_reg;
    assign target_angle      = goal_angle_reg;
    assign drive_on          = attached_reg;
    assign busy_res          = moving_reg;
    assign reported_level    = last_level_reg;
    assign reported_duration = last_duration_reg;

endmodule

@@ rtl/slrc_map.sv @@
// ----------------------------------------------------------------------------
// Servo level ramp controller level mapping
// Two stages: level times angle span, then reciprocal divides, offset, clamp
// and the step delay. Advances as one with the state stage.
// ----------------------------------------------------------------------------
module slrc_map
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic                            in_valid,
    input  logic                            cmd,
    input  logic [slrc_pkg::LEVEL_W-1:0]    level,
    input  logic [slrc_pkg::DUR_W-1:0]      duration,
    input  logic [slrc_pkg::ANGLE_W-1:0]    zero_angle,
    input  logic [slrc_pkg::ANGLE_W-1:0]    full_angle,
    output logic                            item_valid,
    output slrc_pkg::slrc_item_t            item
);

    // Stage 1 registers
    logic                           s1_valid_reg;
    logic                           s1_cmd_reg;
    logic [slrc_pkg::LEVEL_W-1:0]   s1_level_reg;
    logic [slrc_pkg::DUR_W-1:0]     s1_duration_reg;
    logic [14:0]                    s1_mag_reg;
    logic [14:0]                    s1_mag_next;
    logic                           s1_neg_reg;
    logic                           s1_neg_next;
    logic [15:0]                    s1_d50_reg;
    logic [15:0]                    s1_d50_next;
    logic [slrc_pkg::ANGLE_W-1:0]   span_abs;

    // Stage 2 registers
    logic                           s2_valid_reg;
    slrc_pkg::slrc_item_t           s2_item_reg;
    slrc_pkg::slrc_item_t           s2_item_next;
    logic [29:0]                    q_prod;
    logic [8:0]                     quot;
    logic [10:0]                    offset_sum;
    logic [31:0]                    d_prod;

    // Level times span magnitude, sign kept apart so the divide truncates to zero
    always_comb
    begin
        s1_neg_next = (full_angle < zero_angle);
        span_abs    = s1_neg_next ? (zero_angle - full_angle) : (full_angle - zero_angle);
        s1_mag_next = {8'b0, level} * {7'b0, span_abs};
        s1_d50_next = {6'b0, duration} * slrc_pkg::DUR_SCALE;
    end

    // Divide by reciprocal, apply offset and clamp, derive the step delay
    always_comb
    begin
        q_prod     = {15'b0, s1_mag_reg} * {15'b0, slrc_pkg::DIV100_RECIP};
        quot       = 9'(q_prod >> slrc_pkg::DIV100_SHIFT);
        offset_sum = s1_neg_reg ? ({3'b0, zero_angle} - {2'b0, quot})
                                : ({3'b0, zero_angle} + {2'b0, quot});
        d_prod     = {16'b0, s1_d50_reg} * {16'b0, slrc_pkg::DIV9_RECIP};

        s2_item_next.cmd      = s1_cmd_reg;
        s2_item_next.level    = s1_level_reg;
        s2_item_next.duration = s1_duration_reg;
        s2_item_next.delay    = slrc_pkg::TICK_W'(d_prod >> slrc_pkg::DIV9_SHIFT);
        if (offset_sum[10])
        begin
            s2_item_next.goal = '0;
        end
        else if (offset_sum[9:0] > {2'b0, slrc_pkg::MAX_ANGLE})
        begin
            s2_item_next.goal = slrc_pkg::MAX_ANGLE;
        end
        else
        begin
            s2_item_next.goal = offset_sum[7:0];
        end
    end

    // Valid bits of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_cmd_reg      <= cmd;
            s1_level_reg    <= level;
            s1_duration_reg <= duration;
            s1_mag_reg      <= s1_mag_next;
            s1_neg_reg      <= s1_neg_next;
            s1_d50_reg      <= s1_d50_next;
            s2_item_reg     <= s2_item_next;
        end
    end

    assign item_valid = s2_valid_reg;
    assign item       = s2_item_reg;

endmodule

@@ rtl/slrc_checker.sv @@
// ----------------------------------------------------------------------------
// Servo level ramp controller port checker
// Watches the top level ports for slew, range and finish behavior.
// ----------------------------------------------------------------------------
`include "servo_level_ramp_controller_defines.svh"

module slrc_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [7:0]                      cfg_data,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            cmd,
    input  logic [slrc_pkg::LEVEL_W-1:0]    level,
    input  logic [slrc_pkg::DUR_W-1:0]      duration,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [slrc_pkg::ANGLE_W-1:0]    angle,
    input  logic [slrc_pkg::ANGLE_W-1:0]    target_angle,
    input  logic                            drive_on,
    input  logic                            busy_res,
    input  logic [slrc_pkg::LEVEL_W-1:0]    reported_level,
    input  logic [slrc_pkg::DUR_W-1:0]      reported_duration
);

    // A stalled result beat stays put
    `SLRC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(angle) && $stable(target_angle) && $stable(reported_duration), "result beat changed while stalled")

    // Driven angle moves by at most one degree per cycle
    `SLRC_ASSERT_NXT(a_slew, 1'b1, angle == $past(angle) || angle == $past(angle) + 8'd1 || angle == $past(angle) - 8'd1, "angle jumped by more than one degree")

    // Angles stay inside the servo range
    `SLRC_ASSERT_IMP(a_range, out_valid, angle <= slrc_pkg::MAX_ANGLE && target_angle <= slrc_pkg::MAX_ANGLE, "angle outside servo range")

    // A move only finishes on its goal
    `SLRC_ASSERT_IMP(a_finish, $fell(busy_res), angle == target_angle, "move finished away from its goal")

    // Drive attaches only together with a new move
    `SLRC_ASSERT_IMP(a_attach, $rose(drive_on), busy_res, "drive attached without a move")

endmodule

bind servo_level_ramp_controller slrc_checker u_slrc_checker (.*);

@@ tb/sv/tb_servo_level_ramp_controller.sv @@
// ----------------------------------------------------------------------------
// Servo level ramp controller testbench
// Drives set and tick beats through the valid/stall handshake with random
// idling on both sides, predicts every status beat with an in-bench model of
// the slew logic and compares each returned beat field by field. Runs a
// directed corner pass, a full equal-goal hold with detach, random move
// sequences under several endpoint and detach settings, and a long output
// hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_servo_level_ramp_controller;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  PIPE_CYCLES     = 3;
    localparam int  LONG_HOLD_OFF   = 300;
    localparam real RUN_LIMIT_NS    = 5_000_000.0;

    typedef struct packed {
        logic [slrc_pkg::ANGLE_W-1:0] angle;
        logic [slrc_pkg::ANGLE_W-1:0] target;
        logic                         drive;
        logic                         busy;
        logic [slrc_pkg::LEVEL_W-1:0] lvl;
        logic [slrc_pkg::DUR_W-1:0]   dur;
    } servo_status_t;

    // Clock, reset and block ports
    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [1:0]                   cfg_index = slrc_pkg::CFG_ZERO_LEVEL_ANGLE;
    logic [7:0]                   cfg_data = 8'd0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic                         cmd = slrc_pkg::CMD_TICK;
    logic [slrc_pkg::LEVEL_W-1:0] level = '0;
    logic [slrc_pkg::DUR_W-1:0]   duration = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [slrc_pkg::ANGLE_W-1:0] angle;
    logic [slrc_pkg::ANGLE_W-1:0] target_angle;
    logic                         drive_on;
    logic                         busy_res;
    logic [slrc_pkg::LEVEL_W-1:0] reported_level;
    logic [slrc_pkg::DUR_W-1:0]   reported_duration;

    // Predicted servo state and register copies
    logic [slrc_pkg::ANGLE_W-1:0] m_angle;
    logic [slrc_pkg::ANGLE_W-1:0] m_goal;
    logic [slrc_pkg::TICK_W-1:0]  m_countdown;
    logic [slrc_pkg::TICK_W-1:0]  m_delay;
    logic                         m_moving;
    logic                         m_attached;
    logic [slrc_pkg::LEVEL_W-1:0] m_level;
    logic [slrc_pkg::DUR_W-1:0]   m_duration;
    logic [7:0]                   m_zero;
    logic [7:0]                   m_full;
    logic                         m_detach;

    servo_status_t pending_status[$];
    int unsigned   err_count = 0;
    bit            steady = 1'b0;
    bit            long_hold_req = 1'b0;

    servo_level_ramp_controller u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .cmd               (cmd),
        .level             (level),
        .duration          (duration),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .angle             (angle),
        .target_angle      (target_angle),
        .drive_on          (drive_on),
        .busy_res          (busy_res),
        .reported_level    (reported_level),
        .reported_duration (reported_duration)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Return the servo model to its post-reset state
    function automatic void clear_servo_model();
        m_angle     = '0;
        m_goal      = '0;
        m_countdown = '0;
        m_delay     = '0;
        m_moving    = 1'b0;
        m_attached  = 1'b0;
        m_level     = '0;
        m_duration  = '0;
        m_zero      = 8'd0;
        m_full      = 8'd180;
        m_detach    = 1'b0;
    endfunction

    // Move one degree toward the goal and restart the step wait
    function automatic void step_toward_goal();
        if (m_goal > m_angle)
            m_angle = m_angle + 1'b1;
        else if (m_goal < m_angle)
            m_angle = m_angle - 1'b1;
        m_countdown = m_delay;
    endfunction

    // Apply one beat to the servo model and return the status it produces
    function automatic servo_status_t advance_servo_model(
            input logic c,
            input logic [slrc_pkg::LEVEL_W-1:0] lv,
            input logic [slrc_pkg::DUR_W-1:0] du);
        int            span;
        int            mapped;
        servo_status_t st;
        if (c == slrc_pkg::CMD_SET)
        begin
            // Map level onto the endpoints, truncating toward zero, then clamp
            span   = int'(m_full) - int'(m_zero);
            mapped = int'(lv) * span / 100 + int'(m_zero);
            if (mapped < 0)
                mapped = 0;
            if (mapped > int'(slrc_pkg::MAX_ANGLE))
                mapped = int'(slrc_pkg::MAX_ANGLE);
            m_level    = lv;
            m_duration = du;
            m_goal     = mapped[slrc_pkg::ANGLE_W-1:0];
            m_delay    = slrc_pkg::TICK_W'(int'(du) * 50 / 9);
            m_attached = 1'b1;
            m_moving   = 1'b1;
            if (m_goal == m_angle)
                m_countdown = slrc_pkg::EQUAL_HOLD_TICKS;
            else
                step_toward_goal();
        end
        else if (m_moving)
        begin
            if (m_countdown != 0)
                m_countdown = m_countdown - 1'b1;
            if (m_countdown == 0)
            begin
                if (m_angle != m_goal)
                    step_toward_goal();
                else
                begin
                    m_moving = 1'b0;
                    if (m_detach)
                        m_attached = 1'b0;
                end
            end
        end
        st.angle  = m_angle;
        st.target = m_goal;
        st.drive  = m_attached;
        st.busy   = m_moving;
        st.lvl    = m_level;
        st.dur    = m_duration;
        return st;
    endfunction

    // Offer one beat after a random idle gap; record its status on acceptance
    task automatic send_beat(input logic c, input logic [slrc_pkg::LEVEL_W-1:0] lv,
                             input logic [slrc_pkg::DUR_W-1:0] du);
        while (!steady && $urandom_range(0, 99) < 25)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        level    <= lv;
        duration <= du;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_status.push_back(advance_servo_model(c, lv, du));
    endtask

    // Drain the block, then write all three registers on consecutive edges
    task automatic apply_setting(input logic [7:0] zero_ang, input logic [7:0] full_ang,
                                 input logic detach);
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (PIPE_CYCLES + 1) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= slrc_pkg::CFG_ZERO_LEVEL_ANGLE;
        cfg_data  <= zero_ang;
        @(posedge clk);
        cfg_index <= slrc_pkg::CFG_FULL_LEVEL_ANGLE;
        cfg_data  <= full_ang;
        @(posedge clk);
        cfg_index <= slrc_pkg::CFG_DETACH_AFTER_MOVE;
        cfg_data  <= {7'd0, detach};
        @(posedge clk);
        cfg_we    <= 1'b0;
        m_zero   = zero_ang;
        m_full   = full_ang;
        m_detach = detach;
    endtask

    // Reset defaults: idle ticks, equal-goal hold, field extremes, set while busy
    task automatic test_directed_corners();
        send_beat(slrc_pkg::CMD_TICK, 7'd0, 10'd0);
        send_beat(slrc_pkg::CMD_TICK, 7'h7F, 10'h3FF);
        send_beat(slrc_pkg::CMD_SET, 7'd0, 10'd0);
        send_beat(slrc_pkg::CMD_TICK, 7'd0, 10'd0);
        send_beat(slrc_pkg::CMD_TICK, 7'd0, 10'd0);
        send_beat(slrc_pkg::CMD_SET, 7'd127, 10'd1023);
        send_beat(slrc_pkg::CMD_TICK, 7'd0, 10'd0);
        send_beat(slrc_pkg::CMD_TICK, 7'd0, 10'd0);
        send_beat(slrc_pkg::CMD_SET, 7'd100, 10'd1000);
        send_beat(slrc_pkg::CMD_SET, 7'd5, 10'd0);
        repeat (6) send_beat(slrc_pkg::CMD_TICK, 7'd0, 10'd0);
        send_beat(slrc_pkg::CMD_SET, 7'd1, 10'd1);
        repeat (3) send_beat(slrc_pkg::CMD_TICK, 7'd0, 10'd0);
        send_beat(slrc_pkg::CMD_SET, 7'd64, 10'd512);
        send_beat(slrc_pkg::CMD_TICK, 7'd63, 10'd511);
    endtask

    // Run a full equal-goal hold and a complete ramp, both ending in detach
    task automatic test_hold_then_detach();
        int n;
        // Collapse both endpoints onto the driven angle so any level holds
        apply_setting(m_angle, m_angle, 1'b1);
        send_beat(slrc_pkg::CMD_SET, 7'($urandom), 10'($urandom));
        repeat (int'(slrc_pkg::EQUAL_HOLD_TICKS) + 2)
            send_beat(slrc_pkg::CMD_TICK, 7'($urandom), 10'($urandom));
        apply_setting(8'd0, 8'd180, 1'b1);
        send_beat(slrc_pkg::CMD_SET, 7'd50, 10'd0);
        n = (m_angle > m_goal) ? int'(m_angle - m_goal) : int'(m_goal - m_angle);
        repeat (n + 3) send_beat(slrc_pkg::CMD_TICK, 7'($urandom), 10'($urandom));
    endtask

    // Random move sequences under one endpoint and detach setting
    task automatic test_random_moves(input logic [7:0] zero_ang, input logic [7:0] full_ang,
                                     input logic detach, input int beats, input bit quiet);
        int sent;
        int burst;
        logic [slrc_pkg::LEVEL_W-1:0] lv;
        logic [slrc_pkg::DUR_W-1:0]   du;
        apply_setting(zero_ang, full_ang, detach);
        steady = quiet;
        sent   = 0;
        while (sent < beats)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                // Well-formed: a set followed by a burst of ticks
                lv = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(101, 127))
                                                 : 7'($urandom_range(0, 100));
                du = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023))
                                                 : 10'($urandom_range(0, 2));
                burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                    : $urandom_range(1, 30);
                send_beat(slrc_pkg::CMD_SET, lv, du);
                repeat (burst) send_beat(slrc_pkg::CMD_TICK, 7'($urandom), 10'($urandom));
                sent += burst + 1;
            end
            else
            begin
                send_beat(1'($urandom), 7'($urandom), 10'($urandom));
                sent++;
            end
        end
        steady = 1'b0;
    endtask

    // Hold the output off for a long stretch while beats keep coming
    task automatic test_output_backpressure();
        apply_setting(8'd30, 8'd150, 1'b0);
        long_hold_req = 1'b1;
        repeat (150)
        begin
            if ($urandom_range(0, 9) == 0)
                send_beat(slrc_pkg::CMD_SET, 7'($urandom_range(0, 100)),
                          10'($urandom_range(0, 2)));
            else
                send_beat(slrc_pkg::CMD_TICK, 7'($urandom), 10'($urandom));
        end
    endtask

    // Status receiver: random stalls, or a counted hold-off on request
    always @(posedge clk)
    begin : status_receiver
        int hold_left;
        if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD_OFF;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !steady && ($urandom_range(0, 99) < 25);
    end

    // Compare one field and report a mismatch
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    // Match each accepted status beat against the oldest prediction
    always @(posedge clk)
    begin : status_check
        servo_status_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_status.size() == 0)
            begin
                $display("%0t: unexpected status beat, expected none, actual angle %0d",
                         $time, angle);
                err_count++;
            end
            else
            begin
                want = pending_status.pop_front();
                check_field("angle", want.angle, angle);
                check_field("target_angle", want.target, target_angle);
                check_field("drive_on", want.drive, drive_on);
                check_field("busy_res", want.busy, busy_res);
                check_field("reported_level", want.lvl, reported_level);
                check_field("reported_duration", want.dur, reported_duration);
            end
        end
    end

    initial
    begin
        clear_servo_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_hold_then_detach();
        test_random_moves(8'd180, 8'd0, 1'b1, 100, 1'b0);
        test_random_moves(8'd0, 8'd0, 1'b0, 120, 1'b1);
        test_random_moves(8'd255, 8'd255, 1'b1, 80, 1'b0);
        test_random_moves(8'd90, 8'd45, 1'b0, 100, 1'b0);
        test_random_moves(8'd0, 8'd255, 1'b1, 80, 1'b0);
        test_random_moves(8'($urandom), 8'($urandom), 1'($urandom), 80, 1'b0);
        test_output_backpressure();

        // Drain outstanding status, then watch for strays
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (PIPE_CYCLES + 7) @(posedge clk);
        if (err_count == 0)
            $display("[servo_level_ramp_controller] OK");
        else
            $display("[servo_level_ramp_controller] ERROR");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("%0t: run limit reached with %0d status beats outstanding",
                 $time, pending_status.size());
        $display("[servo_level_ramp_controller] ERROR");
        $finish;
    end

endmodule
